// File: design/tcsr_pkg.sv
// ----------------------------------------------------------------------------
// tcsr_pkg: shared types and constants of the text cell shade renderer
// Palette layout, operation codes, character classes and the code classifier.
// ----------------------------------------------------------------------------
package tcsr_pkg;

	localparam int unsigned PAL_DEPTH = 16;
	localparam int unsigned PAL_AW    = 4;
	localparam int unsigned CHAN_W    = 6;
	localparam int unsigned ENTRY_W   = 3 * CHAN_W;
	localparam int unsigned PIX_W     = 24;

	// operation codes of an input item
	localparam logic OP_RENDER = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	// character codes with a special look
	localparam logic [7:0] CH_NUL    = 8'd0;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_DASH   = 8'd45;
	localparam logic [7:0] CH_LETTER = 8'd65;
	localparam logic [7:0] CH_LIGHT  = 8'd176;
	localparam logic [7:0] CH_MEDIUM = 8'd177;
	localparam logic [7:0] CH_DARK   = 8'd178;
	localparam logic [7:0] CH_HLINE  = 8'd196;
	localparam logic [7:0] CH_LHALF  = 8'd221;
	localparam logic [7:0] CH_RHALF  = 8'd222;
	localparam logic [7:0] CH_UHALF  = 8'd223;
	localparam logic [7:0] CH_FULL   = 8'd255;

	// how a cell is drawn
	typedef enum logic [2:0] {
		CLS_BG    = 3'd0,  // both pixels background
		CLS_SPLIT = 3'd1,  // top foreground, bottom background
		CLS_DARK  = 3'd2,  // 3:1 foreground blend
		CLS_HALF  = 3'd3,  // 1:1 blend
		CLS_LIGHT = 3'd4,  // 1:3 foreground blend
		CLS_FG    = 3'd5   // both pixels foreground
	} cell_cls_t;

	// control that travels with a cell into the shading logic
	typedef struct packed {
		cell_cls_t cls;
		logic      blank;
		logic      fg_ok;  // foreground entry written since reset
		logic      bg_ok;  // background entry written since reset
	} cell_ctl_t;

	function automatic cell_cls_t classify(input logic [7:0] code);
		cell_cls_t c;
		case (code)
			CH_NUL, CH_SPACE, CH_FULL:    c = CLS_BG;
			CH_HLINE, CH_UHALF, CH_DASH:  c = CLS_SPLIT;
			CH_DARK:                      c = CLS_DARK;
			CH_MEDIUM, CH_LHALF, CH_RHALF: c = CLS_HALF;
			CH_LIGHT:                     c = CLS_LIGHT;
			default:                      c = CLS_FG;
		endcase
		return c;
	endfunction

endpackage

// File: design/text_cell_shade_renderer_core.sv
// ----------------------------------------------------------------------------
// text_cell_shade_renderer_core: text cell to two pixel colours
// Palette RAM, cell stage and output register with valid/ready on both sides.
// ----------------------------------------------------------------------------
// Path: an accepted render item is held by the registered palette read and
// the cell stage, then by the output register until out_ready takes it.
// One item per cycle unless the output stalls; the palette read is registered
// in the RAM and the blend sits between that read and the output register.
// Palette writes give no result and are seen by the very next render item.
// Reset clears the pipeline valids and the palette written-flags, so every
// palette entry reads as zero until written. No clearing pass is needed.
module text_cell_shade_renderer_core import tcsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [7:0]        char_code,
	input  logic [7:0]        attribute,
	input  logic              blank,
	input  logic [3:0]        entry_index,
	input  logic [5:0]        red_in,
	input  logic [5:0]        green_in,
	input  logic [5:0]        blue_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [23:0]       top_colour,
	output logic [23:0]       bottom_colour
);

	logic               in_acc;
	logic               wr_acc;
	logic               rd_acc;
	logic               adv;
	logic [PAL_DEPTH-1:0] pal_ok_q;
	logic               vld_s1;
	cell_ctl_t          ctl_s1;
	logic [ENTRY_W-1:0] fg_entry;
	logic [ENTRY_W-1:0] bg_entry;
	logic [PIX_W-1:0]   top_pix;
	logic [PIX_W-1:0]   bot_pix;
	logic               out_vld_q;
	logic [PIX_W-1:0]   top_q;
	logic [PIX_W-1:0]   bot_q;

	// handshake
	assign adv      = !out_vld_q || out_ready;
	assign in_ready = !vld_s1 || adv;
	assign in_acc   = in_valid && in_ready;
	assign wr_acc   = in_acc && (operation == OP_WRITE);
	assign rd_acc   = in_acc && (operation == OP_RENDER);

	// palette storage, read at the foreground and background indexes
	tcsr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PAL_DEPTH)
	) u_pal (
		.clk     (clk),
		.we      (wr_acc),
		.waddr   (entry_index),
		.wdata   ({red_in, green_in, blue_in}),
		.re      (rd_acc),
		.raddr_a (attribute[3:0]),
		.raddr_b (attribute[7:4]),
		.rdata_a (fg_entry),
		.rdata_b (bg_entry)
	);

	// written-flags, one per palette entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_ok_q <= '0;
		end else if (wr_acc) begin
			pal_ok_q[entry_index] <= 1'b1;
		end
	end

	// cell stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= rd_acc;
		end
	end

	// cell stage control
	always_ff @(posedge clk) begin
		if (rd_acc) begin
			ctl_s1.cls   <= classify(char_code);
			ctl_s1.blank <= blank;
			ctl_s1.fg_ok <= pal_ok_q[attribute[3:0]];
			ctl_s1.bg_ok <= pal_ok_q[attribute[7:4]];
		end
	end

	tcsr_shade u_shade (
		.ctl        (ctl_s1),
		.fg_entry   (fg_entry),
		.bg_entry   (bg_entry),
		.top_pix    (top_pix),
		.bottom_pix (bot_pix)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			top_q <= top_pix;
			bot_q <= bot_pix;
		end
	end

	assign out_valid     = out_vld_q;
	assign top_colour    = top_q;
	assign bottom_colour = bot_q;

endmodule

// File: design/tcsr_ram.sv
// ----------------------------------------------------------------------------
// tcsr_ram: generic RAM, one write port, two registered read ports
// Read data updates only on a read enable and holds otherwise.
// ----------------------------------------------------------------------------
module tcsr_ram #(
	parameter int unsigned WIDTH = 18,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// File: design/tcsr_shade.sv
// ----------------------------------------------------------------------------
// tcsr_shade: per-channel blend of foreground and background
// Background, foreground, split, weighted blend or black; packs 0xRRGGBB.
// ----------------------------------------------------------------------------
module tcsr_shade import tcsr_pkg::*; (
	input  cell_ctl_t          ctl,
	input  logic [ENTRY_W-1:0] fg_entry,
	input  logic [ENTRY_W-1:0] bg_entry,
	output logic [PIX_W-1:0]   top_pix,
	output logic [PIX_W-1:0]   bottom_pix
);

	logic [ENTRY_W-1:0] fe;
	logic [ENTRY_W-1:0] be;

	// entries never written read as zero
	assign fe = ctl.fg_ok ? fg_entry : '0;
	assign be = ctl.bg_ok ? bg_entry : '0;

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [CHAN_W-1:0] f;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W+1:0] sum;
		logic [CHAN_W-1:0] top_v;
		logic [CHAN_W-1:0] bot_v;

		assign f = fe[ENTRY_W-1-CHAN_W*c -: CHAN_W];
		assign b = be[ENTRY_W-1-CHAN_W*c -: CHAN_W];

		// weighted sum, weights add up to four
		always_comb begin
			case (ctl.cls)
				CLS_DARK:  sum = {1'b0, f, 1'b0} + {2'b00, f} + {2'b00, b};
				CLS_HALF:  sum = {1'b0, f, 1'b0} + {1'b0, b, 1'b0};
				CLS_LIGHT: sum = {2'b00, f} + {1'b0, b, 1'b0} + {2'b00, b};
				default:   sum = '0;
			endcase
		end

		always_comb begin
			case (ctl.cls)
				CLS_BG: begin
					top_v = b;
					bot_v = b;
				end
				CLS_SPLIT: begin
					top_v = f;
					bot_v = b;
				end
				CLS_DARK, CLS_HALF, CLS_LIGHT: begin
					top_v = sum[CHAN_W+1:2];
					bot_v = sum[CHAN_W+1:2];
				end
				default: begin
					top_v = f;
					bot_v = f;
				end
			endcase
			if (ctl.blank) begin
				top_v = '0;
				bot_v = '0;
			end
		end

		// channel times four into its byte
		assign top_pix[PIX_W-1-8*c -: 8]    = {top_v, 2'b00};
		assign bottom_pix[PIX_W-1-8*c -: 8] = {bot_v, 2'b00};
	end

endmodule

// File: design/tcsr_checker.sv
// ----------------------------------------------------------------------------
// tcsr_checker: port-level checks of the text cell shade renderer
// Stall behavior, backpressure, blank cells and palette write-to-read.
// ----------------------------------------------------------------------------
module tcsr_checker import tcsr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        operation,
	input logic [7:0]  char_code,
	input logic [7:0]  attribute,
	input logic        blank,
	input logic [3:0]  entry_index,
	input logic [5:0]  red_in,
	input logic [5:0]  green_in,
	input logic [5:0]  blue_in,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] top_colour,
	input logic [23:0] bottom_colour
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top_colour)
			&& $stable(bottom_colour))
		else $error("stalled result changed");

	// input side blocks only when both stages are full and the output stalls
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without output backpressure");

	// a blank cell is black on both pixels
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_RENDER && blank ##1 out_ready
		|=> out_valid && top_colour == 24'h0 && bottom_colour == 24'h0)
		else $error("blank cell not black");

	// a palette write is seen by the next plain render of that entry
	a_wr_rd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_WRITE
		##1 in_valid && in_ready && operation == OP_RENDER && !blank
			&& char_code == CH_LETTER && attribute[3:0] == $past(entry_index)
		##1 out_ready
		|=> out_valid && top_colour == {$past(red_in, 3), 2'b00,
			$past(green_in, 3), 2'b00, $past(blue_in, 3), 2'b00})
		else $error("palette write not seen by next render");

endmodule

bind text_cell_shade_renderer_core tcsr_checker u_tcsr_checker (.*);

// File: tb/tb_text_cell_shade_renderer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_cell_shade_renderer_core: self-checking bench of the cell renderer
// Streams palette writes and cell renders through the valid/ready input,
// predicts both pixel colours of every render and checks them in order
// against the output, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_text_cell_shade_renderer_core;
	import tcsr_pkg::*;

	typedef struct packed {
		logic       op;
		logic [7:0] code;
		logic [7:0] attr;
		logic       blank;
		logic [3:0] idx;
		logic [5:0] red;
		logic [5:0] green;
		logic [5:0] blue;
	} cell_item_t;

	typedef struct packed {
		logic [23:0] top;
		logic [23:0] bottom;
	} pix_pair_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	cell_item_t  bus    = '0;
	logic        in_valid  = 1'b0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [23:0] top_colour;
	logic [23:0] bottom_colour;

	cell_item_t  pending_cells [$];
	pix_pair_t   expected_pixels [$];
	logic [17:0] palette_model [PAL_DEPTH];
	int unsigned fail_cnt = 0;

	// codes with a look of their own, favored by the random stimulus
	logic [7:0] shade_codes [12] = '{CH_NUL, CH_SPACE, CH_FULL, CH_HLINE, CH_UHALF,
		CH_DASH, CH_DARK, CH_MEDIUM, CH_LHALF, CH_RHALF, CH_LIGHT, CH_LETTER};

	text_cell_shade_renderer_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (bus.op),
		.char_code     (bus.code),
		.attribute     (bus.attr),
		.blank         (bus.blank),
		.entry_index   (bus.idx),
		.red_in        (bus.red),
		.green_in      (bus.green),
		.blue_in       (bus.blue),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.top_colour    (top_colour),
		.bottom_colour (bottom_colour)
	);

	always #1 clk = ~clk;

	// per-channel weighted mix of fg and bg, wf out of 4, packed 0xRRGGBB
	function automatic logic [23:0] mix_pixel(logic [17:0] fe, logic [17:0] be,
		int unsigned wf);
		logic [23:0] px;
		int unsigned f;
		int unsigned b;
		int unsigned v;
		px = '0;
		for (int c = 0; c < 3; c++) begin
			f  = (fe >> (12 - 6 * c)) & 6'h3f;
			b  = (be >> (12 - 6 * c)) & 6'h3f;
			v  = (f * wf + b * (4 - wf)) >> 2;
			px = {px[15:0], v[5:0], 2'b00};
		end
		return px;
	endfunction

	function automatic pix_pair_t shade_cell(cell_item_t it);
		pix_pair_t   p;
		logic [17:0] fe;
		logic [17:0] be;
		fe = palette_model[it.attr[3:0]];
		be = palette_model[it.attr[7:4]];
		if (it.blank) begin
			p = '0;
		end else begin
			case (it.code)
				CH_NUL, CH_SPACE, CH_FULL: begin
					p.top    = mix_pixel(fe, be, 0);
					p.bottom = p.top;
				end
				CH_HLINE, CH_UHALF, CH_DASH: begin
					p.top    = mix_pixel(fe, be, 4);
					p.bottom = mix_pixel(fe, be, 0);
				end
				CH_DARK: begin
					p.top    = mix_pixel(fe, be, 3);
					p.bottom = p.top;
				end
				CH_MEDIUM, CH_LHALF, CH_RHALF: begin
					p.top    = mix_pixel(fe, be, 2);
					p.bottom = p.top;
				end
				CH_LIGHT: begin
					p.top    = mix_pixel(fe, be, 1);
					p.bottom = p.top;
				end
				default: begin
					p.top    = mix_pixel(fe, be, 4);
					p.bottom = p.top;
				end
			endcase
		end
		return p;
	endfunction

	function automatic cell_item_t mk_render(logic [7:0] code, logic [7:0] attr,
		logic blank);
		cell_item_t it;
		it       = '0;
		it.op    = OP_RENDER;
		it.code  = code;
		it.attr  = attr;
		it.blank = blank;
		return it;
	endfunction

	function automatic cell_item_t mk_write(logic [3:0] idx, logic [5:0] r,
		logic [5:0] g, logic [5:0] b);
		cell_item_t it;
		it       = '0;
		it.op    = OP_WRITE;
		it.idx   = idx;
		it.red   = r;
		it.green = g;
		it.blue  = b;
		return it;
	endfunction

	function automatic logic [5:0] rand_chan();
		case ($urandom_range(0, 5))
			0:       return 6'd0;
			1:       return 6'd63;
			default: return 6'($urandom_range(0, 63));
		endcase
	endfunction

	// random item; unused fields carry random bits too
	function automatic cell_item_t rand_item();
		cell_item_t it;
		it       = cell_item_t'({$urandom, $urandom});
		if ($urandom_range(0, 3) == 0) begin
			it.op    = OP_WRITE;
			it.red   = rand_chan();
			it.green = rand_chan();
			it.blue  = rand_chan();
		end else begin
			it.op    = OP_RENDER;
			if ($urandom_range(0, 1) == 0)
				it.code = shade_codes[$urandom_range(0, 11)];
			it.blank = ($urandom_range(0, 9) == 0);
		end
		return it;
	endfunction

	// sender: bursts of random length from the pending queue, random gaps between
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			bus        <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			// item taken this edge: update the palette copy or predict the pixels
			if (in_valid && in_ready) begin
				if (bus.op == OP_WRITE)
					palette_model[bus.idx] = {bus.red, bus.green, bus.blue};
				else
					expected_pixels.push_back(shade_cell(bus));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_cells.size() > 0) begin
					bus      <= pending_cells.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches mode every so often
	int unsigned rx_mode = 0;
	int unsigned rx_left = 0;
	int unsigned rx_phase = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode   <= 0;
			rx_left   <= 0;
			rx_phase  <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_left <= $urandom_range(32, 256);
			end else begin
				rx_left <= rx_left - 1;
			end
			rx_phase <= rx_phase + 1;
			case (rx_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= $urandom_range(0, 1);
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (rx_phase % 5) < 2;
			endcase
		end
	end

	// checker: each accepted result against the oldest prediction
	always @(posedge clk) begin
		pix_pair_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected result: top_colour %06h bottom_colour %06h",
					top_colour, bottom_colour);
				fail_cnt++;
			end else begin
				want = expected_pixels.pop_front();
				if (top_colour !== want.top) begin
					$error("top_colour mismatch: expected %06h, actual %06h",
						want.top, top_colour);
					fail_cnt++;
				end
				if (bottom_colour !== want.bottom) begin
					$error("bottom_colour mismatch: expected %06h, actual %06h",
						want.bottom, bottom_colour);
					fail_cnt++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int unsigned sent;
		int unsigned chunk;
		bit          drain_first;
		for (int i = 0; i < PAL_DEPTH; i++)
			palette_model[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unwritten entries read zero, extremes, every cell class
		pending_cells.push_back(mk_render(CH_LETTER, 8'hF0, 1'b0));
		pending_cells.push_back(mk_render(CH_DARK, 8'h3C, 1'b0));
		pending_cells.push_back(mk_write(4'd15, 6'd63, 6'd63, 6'd63));
		pending_cells.push_back(mk_write(4'd0, 6'd1, 6'd2, 6'd3));
		pending_cells.push_back(mk_write(4'd9, 6'd63, 6'd0, 6'd21));
		pending_cells.push_back(mk_render(CH_DARK, 8'h0F, 1'b0));
		pending_cells.push_back(mk_render(CH_MEDIUM, 8'h0F, 1'b0));
		pending_cells.push_back(mk_render(CH_LHALF, 8'h9F, 1'b0));
		pending_cells.push_back(mk_render(CH_RHALF, 8'hF9, 1'b0));
		pending_cells.push_back(mk_render(CH_LIGHT, 8'h0F, 1'b0));
		pending_cells.push_back(mk_render(CH_HLINE, 8'h0F, 1'b0));
		pending_cells.push_back(mk_render(CH_UHALF, 8'hF0, 1'b0));
		pending_cells.push_back(mk_render(CH_DASH, 8'h9F, 1'b0));
		pending_cells.push_back(mk_render(CH_NUL, 8'h9F, 1'b0));
		pending_cells.push_back(mk_render(CH_SPACE, 8'hF9, 1'b0));
		pending_cells.push_back(mk_render(CH_FULL, 8'h0F, 1'b0));
		pending_cells.push_back(mk_render(CH_LETTER, 8'hF9, 1'b0));
		// blank cells are black whatever the code and colours
		pending_cells.push_back(mk_render(CH_DARK, 8'hFF, 1'b1));
		pending_cells.push_back(mk_render(CH_LETTER, 8'h0F, 1'b1));
		// write seen by the render right behind it
		pending_cells.push_back(mk_write(4'd15, 6'd0, 6'd63, 6'd0));
		pending_cells.push_back(mk_render(CH_LETTER, 8'h0F, 1'b0));
		pending_cells.push_back(mk_render(CH_DARK, 8'hFF, 1'b0));
		pending_cells.push_back(mk_render(8'd254, 8'h90, 1'b0));

		// random: chunks; the directed items and some chunks are drained before the next
		sent        = 0;
		drain_first = 1'b1;
		while (sent < 2000) begin
			while (pending_cells.size() > 0) @(posedge clk);
			if (drain_first || $urandom_range(0, 2) == 0) begin
				while (in_valid || expected_pixels.size() > 0) @(posedge clk);
				drain_first = 1'b0;
			end
			chunk = $urandom_range(50, 300);
			for (int i = 0; i < chunk; i++)
				pending_cells.push_back(rand_item());
			sent += chunk;
		end

		// wind down: all items taken, all results in, then the verdict
		while (pending_cells.size() > 0 || in_valid) @(posedge clk);
		while (expected_pixels.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_cnt == 0 && expected_pixels.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
